// File: hdl/dbim_pkg.sv
// Shared types and constants for the decimal big-integer multiplier.
// No dependencies; used by the channel interfaces and all modules.

package dbim_pkg;

  localparam int unsigned MAX_DIGITS  = 32;
  localparam int unsigned PROD_DIGITS = 2 * MAX_DIGITS;
  localparam int unsigned IDX_W       = $clog2(MAX_DIGITS);
  localparam int unsigned PIDX_W      = $clog2(PROD_DIGITS);
  // column sum plus carry stays below MAX_DIGITS * 90
  localparam int unsigned SUM_W       = $clog2(MAX_DIGITS * 90 + 1);

  localparam int unsigned DIV_SH      = 20;
  localparam int unsigned DIV_RECIP   = (1 << DIV_SH) / 10;
  localparam int unsigned DIV_RECIP_W = $clog2(DIV_RECIP + 1);

  localparam int unsigned POS_W       = 5;
  localparam int unsigned DIGIT_W     = 4;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [POS_W-1:0]   position;
    logic [DIGIT_W-1:0] digit;
    logic               a_negative;
    logic               b_negative;
  } in_beat_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] product_digit;
    logic               negative;
    logic               last;
  } out_beat_t;

endpackage

// File: hdl/dbim_in_if.sv
// Input channel of the decimal big-integer multiplier: valid/ready plus one beat.
// Depends on dbim_pkg.

interface dbim_in_if;
  import dbim_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/dbim_out_if.sv
// Result channel of the decimal big-integer multiplier: valid/ready plus one beat.
// Depends on dbim_pkg.

interface dbim_out_if;
  import dbim_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/dbim_div10.sv
// Divide-by-ten: reciprocal multiply, register, one correction step.
// Depends on dbim_pkg.

module dbim_div10 (
  input  logic                      clk,
  input  logic [dbim_pkg::SUM_W-1:0] value_i,
  output logic [dbim_pkg::SUM_W-1:0] quot_o,
  output logic [3:0]                 rem_o
);
  import dbim_pkg::*;

  localparam int unsigned PW = SUM_W + DIV_RECIP_W;

  logic [PW-1:0]    prod_w;
  logic [SUM_W-1:0] q0_r;
  logic [SUM_W-1:0] v_r;
  logic [SUM_W-1:0] r0_w;

  assign prod_w = PW'(value_i) * PW'(DIV_RECIP);

  always_ff @(posedge clk) begin
    q0_r <= SUM_W'(prod_w >> DIV_SH);
    v_r  <= value_i;
  end

  // estimate is low by at most one
  assign r0_w = v_r - SUM_W'(q0_r * 4'd10);

  always_comb begin
    if (r0_w >= SUM_W'(10)) begin
      quot_o = q0_r + SUM_W'(1);
      rem_o  = 4'(r0_w - SUM_W'(10));
    end else begin
      quot_o = q0_r;
      rem_o  = 4'(r0_w);
    end
  end
endmodule

// File: hdl/decimal_big_integer_multiplier.sv
// Decimal big-integer multiplier, top level.
// Depends on dbim_pkg, dbim_in_if, dbim_out_if and dbim_div10.
//
// Usage: the in_chan channel takes one beat per cycle while idle. A beat of
// kind load-A or load-B writes a digit (values above nine saturate to nine)
// at its position in the A or B store; positions beyond the store are
// dropped. A start beat multiplies the stores, sign = a_negative ^ b_negative.
// The product digits leave on out_chan, most significant first, leading zeros
// suppressed; the first beat carries the sign and the final beat has last
// set. A zero product is one non-negative 0 beat. Both stores read as zero
// again after a product.
// Sequence: a start beat is followed by the convolution (one digit product
// per cycle through a single multiply-accumulate, then the shared
// divide-by-ten unit for the carry of each column), then for each output
// digit a digit RAM read, then the output beat. in_chan.ready stays low from
// the start beat until the last digit is taken.
// A stalled receiver holds the output beat unchanged. Synchronous reset
// returns to idle with empty operand stores.

module decimal_big_integer_multiplier (
  input  logic      clk,
  input  logic      rst_n,
  dbim_in_if.sink   in_chan,
  dbim_out_if.source out_chan
);
  import dbim_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DIV1,
    S_DIV2,
    S_RD,
    S_OUT
  } state_t;

  state_t              state_r;
  logic [PIDX_W-1:0]   k_r;
  logic [IDX_W-1:0]    i_r;
  logic [SUM_W-1:0]    acc_r;
  logic [SUM_W-1:0]    carry_r;
  logic [PIDX_W-1:0]   top_r;
  logic                nz_r;
  logic                neg_r;
  logic                first_r;
  logic [DIGIT_W-1:0]  rd_r;

  logic [DIGIT_W-1:0]  a_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0]  b_mem [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] a_vld_r;
  logic [MAX_DIGITS-1:0] b_vld_r;
  logic [DIGIT_W-1:0]  p_mem [PROD_DIGITS];

  logic                in_acc;
  logic                out_acc;
  logic                pos_ok;
  logic [IDX_W-1:0]    wr_idx;
  logic [DIGIT_W-1:0]  dsat;
  logic [PIDX_W-1:0]   diff_w;
  logic                j_ok;
  logic [IDX_W-1:0]    j_idx;
  logic [DIGIT_W-1:0]  a_rd;
  logic [DIGIT_W-1:0]  b_rd;
  logic [7:0]          mul_w;
  logic [SUM_W-1:0]    acc_nxt;
  logic [SUM_W-1:0]    quot_w;
  logic [3:0]          rem_w;
  logic                i_last;
  logic                k_last;
  logic [PIDX_W-1:0]   top_nxt;
  logic                nz_nxt;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  assign in_chan.ready = (state_r == S_IDLE);
  assign out_chan.valid = (state_r == S_OUT);
  assign out_chan.data.product_digit = rd_r;
  assign out_chan.data.negative      = first_r && neg_r && nz_r;
  assign out_chan.data.last          = (k_r == '0);

  assign pos_ok = 32'(in_chan.data.position) < MAX_DIGITS;
  assign wr_idx = IDX_W'(in_chan.data.position);
  assign dsat   = (in_chan.data.digit > 4'd9) ? 4'd9 : in_chan.data.digit;

  // column k, row i pairs with j = k - i when that lands inside B
  assign diff_w = k_r - PIDX_W'(i_r);
  assign j_ok   = (k_r >= PIDX_W'(i_r)) && (diff_w < PIDX_W'(MAX_DIGITS));
  assign j_idx  = IDX_W'(diff_w);
  assign a_rd   = a_vld_r[i_r] ? a_mem[i_r] : '0;
  assign b_rd   = (j_ok && b_vld_r[j_idx]) ? b_mem[j_idx] : '0;
  assign mul_w  = a_rd * b_rd;
  assign acc_nxt = acc_r + SUM_W'(mul_w);

  assign i_last = (i_r == IDX_W'(MAX_DIGITS - 1));
  assign k_last = (k_r == PIDX_W'(PROD_DIGITS - 1));

  assign top_nxt = (rem_w != '0) ? k_r : top_r;
  assign nz_nxt  = nz_r || (rem_w != '0);

  dbim_div10 u_div10 (
    .clk     (clk),
    .value_i (acc_r),
    .quot_o  (quot_w),
    .rem_o   (rem_w)
  );

  always_ff @(posedge clk) begin
    if (in_acc && pos_ok && in_chan.data.kind == KIND_LOAD_A) begin
      a_mem[wr_idx] <= dsat;
    end
    if (in_acc && pos_ok && in_chan.data.kind == KIND_LOAD_B) begin
      b_mem[wr_idx] <= dsat;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV2) begin
      p_mem[k_r] <= rem_w;
    end
    if (state_r == S_RD) begin
      rd_r <= p_mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_vld_r <= '0;
      b_vld_r <= '0;
      k_r     <= '0;
      i_r     <= '0;
      acc_r   <= '0;
      carry_r <= '0;
      top_r   <= '0;
      nz_r    <= 1'b0;
      neg_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_chan.data.kind == KIND_LOAD_A && pos_ok) begin
              a_vld_r[wr_idx] <= 1'b1;
            end
            if (in_chan.data.kind == KIND_LOAD_B && pos_ok) begin
              b_vld_r[wr_idx] <= 1'b1;
            end
            if (in_chan.data.kind == KIND_START) begin
              state_r <= S_MAC;
              k_r     <= '0;
              i_r     <= '0;
              acc_r   <= '0;
              carry_r <= '0;
              top_r   <= '0;
              nz_r    <= 1'b0;
              neg_r   <= in_chan.data.a_negative ^ in_chan.data.b_negative;
              first_r <= 1'b1;
            end
          end
        end
        S_MAC: begin
          if (i_last) begin
            acc_r   <= acc_nxt + carry_r;
            state_r <= S_DIV1;
          end else begin
            acc_r <= acc_nxt;
            i_r   <= i_r + IDX_W'(1);
          end
        end
        S_DIV1: begin
          state_r <= S_DIV2;
        end
        S_DIV2: begin
          carry_r <= quot_w;
          top_r   <= top_nxt;
          nz_r    <= nz_nxt;
          acc_r   <= '0;
          i_r     <= '0;
          if (k_last) begin
            k_r     <= top_nxt;
            a_vld_r <= '0;
            b_vld_r <= '0;
            state_r <= S_RD;
          end else begin
            k_r     <= k_r + PIDX_W'(1);
            state_r <= S_MAC;
          end
        end
        S_RD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_acc) begin
            first_r <= 1'b0;
            if (k_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r - PIDX_W'(1);
              state_r <= S_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
